// File: sv/ttsd_pkg.sv
// Shared constants and types for the touch tap and swipe detector.
package ttsd_pkg;

   localparam int PX_WIDTH   = 10;
   localparam int MS_WIDTH   = 16;
   localparam int TIME_WIDTH = 32;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef logic [1:0] gesture_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam gesture_type GESTURE_TAP  = 2'd0;
   localparam gesture_type GESTURE_NEXT = 2'd1;
   localparam gesture_type GESTURE_PREV = 2'd2;

   localparam csr_index_type REG_TAP_MAX_PX   = 3'd0;
   localparam csr_index_type REG_TAP_MAX_MS   = 3'd1;
   localparam csr_index_type REG_SLIDE_MIN_PX = 3'd2;
   localparam csr_index_type REG_TAP_GAP_MS   = 3'd3;
   localparam csr_index_type REG_SLIDE_GAP_MS = 3'd4;

   localparam logic [PX_WIDTH-1:0] TAP_MAX_PX_RESET   = 10'd20;
   localparam logic [MS_WIDTH-1:0] TAP_MAX_MS_RESET   = 16'd300;
   localparam logic [PX_WIDTH-1:0] SLIDE_MIN_PX_RESET = 10'd40;
   localparam logic [MS_WIDTH-1:0] TAP_GAP_MS_RESET   = 16'd120;
   localparam logic [MS_WIDTH-1:0] SLIDE_GAP_MS_RESET = 16'd250;

endpackage

// File: sv/touch_tap_swipe_detector.sv
// Tap and swipe gesture detector over a stream of touch polls.
//
//   channel   direction   tdata fields (low bit up)     tuser
//   req       in          pos_x, pos_y, now_ms          touched
//   rsp       out         gesture                       -
//
//   csr       in/out      APB registers 0..4 at 4*i     -
//
// A poll is decided once its request is taken into the input register, and its result
// is registered as the decision advances; one poll is taken per cycle while no pending result stalls a producing poll.
// The throughput is set by the single decision stage that reads and updates the
// gesture state in the same cycle.
// Reset is synchronous and restores the register defaults and the idle phase.
// A stalled result only holds back polls that would produce another result.
module touch_tap_swipe_detector #(
   parameter int COORD_WIDTH = 10
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // tdata: pos_x, pos_y, now_ms, zero padding
   input  logic [((2*COORD_WIDTH+ttsd_pkg::TIME_WIDTH+7)/8)*8-1:0] req_tdata,
   // tuser: touched
   input  logic [0:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // tdata: gesture, zero padding
   output logic [7:0] rsp_tdata,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [ttsd_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [ttsd_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [ttsd_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic csr_pready
);
   import ttsd_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int DW = (CW > PX_WIDTH) ? CW : PX_WIDTH;

   logic [PX_WIDTH-1:0] tap_max_px_ff;
   logic [MS_WIDTH-1:0] tap_max_ms_ff;
   logic [PX_WIDTH-1:0] slide_min_px_ff;
   logic [MS_WIDTH-1:0] tap_gap_ms_ff;
   logic [MS_WIDTH-1:0] slide_gap_ms_ff;

   logic                  s1_valid_ff;
   logic                  s1_touched_ff;
   logic [CW-1:0]         s1_x_ff;
   logic [CW-1:0]         s1_y_ff;
   logic [TIME_WIDTH-1:0] s1_now_ff;

   logic                  pressed_ff, pressed_in;
   logic                  moved_ff, moved_in;
   logic [CW-1:0]         origin_x_ff, origin_x_in;
   logic [CW-1:0]         origin_y_ff, origin_y_in;
   logic [TIME_WIDTH-1:0] press_time_ff, press_time_in;
   logic [TIME_WIDTH-1:0] last_event_ff, last_event_in;

   logic        rsp_valid_ff;
   gesture_type rsp_gesture_ff;

   logic                  csr_write;
   csr_index_type         csr_index;
   logic [CW-1:0]         adx, ady;
   logic [TIME_WIDTH-1:0] dur, gap;
   logic                  press_start, holding, releasing;
   logic                  exceed, moved_now, slide_dist, negative;
   logic                  ev_tap, ev_slide, produce, advance;
   gesture_type           ev_gesture;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_WIDTH-1:2];

   always_comb begin
      unique case (csr_index)
         REG_TAP_MAX_PX:   csr_prdata = CSR_DATA_WIDTH'(tap_max_px_ff);
         REG_TAP_MAX_MS:   csr_prdata = CSR_DATA_WIDTH'(tap_max_ms_ff);
         REG_SLIDE_MIN_PX: csr_prdata = CSR_DATA_WIDTH'(slide_min_px_ff);
         REG_TAP_GAP_MS:   csr_prdata = CSR_DATA_WIDTH'(tap_gap_ms_ff);
         REG_SLIDE_GAP_MS: csr_prdata = CSR_DATA_WIDTH'(slide_gap_ms_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_max_px_ff   <= TAP_MAX_PX_RESET;
         tap_max_ms_ff   <= TAP_MAX_MS_RESET;
         slide_min_px_ff <= SLIDE_MIN_PX_RESET;
         tap_gap_ms_ff   <= TAP_GAP_MS_RESET;
         slide_gap_ms_ff <= SLIDE_GAP_MS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_TAP_MAX_PX:   tap_max_px_ff   <= csr_pwdata[PX_WIDTH-1:0];
            REG_TAP_MAX_MS:   tap_max_ms_ff   <= csr_pwdata[MS_WIDTH-1:0];
            REG_SLIDE_MIN_PX: slide_min_px_ff <= csr_pwdata[PX_WIDTH-1:0];
            REG_TAP_GAP_MS:   tap_gap_ms_ff   <= csr_pwdata[MS_WIDTH-1:0];
            REG_SLIDE_GAP_MS: slide_gap_ms_ff <= csr_pwdata[MS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign adx = (s1_x_ff >= origin_x_ff) ? s1_x_ff - origin_x_ff : origin_x_ff - s1_x_ff;
   assign ady = (s1_y_ff >= origin_y_ff) ? s1_y_ff - origin_y_ff : origin_y_ff - s1_y_ff;
   assign dur = s1_now_ff - press_time_ff;
   assign gap = s1_now_ff - last_event_ff;

   assign press_start = s1_touched_ff && !pressed_ff;
   assign holding     = s1_touched_ff && pressed_ff;
   assign releasing   = !s1_touched_ff && pressed_ff;

   assign exceed     = (DW'(adx) > DW'(tap_max_px_ff)) || (DW'(ady) > DW'(tap_max_px_ff));
   assign moved_now  = holding && (moved_ff || exceed);
   assign slide_dist = (DW'(adx) >= DW'(slide_min_px_ff))
                    || (DW'(ady) >= DW'(slide_min_px_ff));
   assign ev_slide   = moved_now && slide_dist && (gap > TIME_WIDTH'(slide_gap_ms_ff));
   assign ev_tap     = releasing && !moved_ff && (dur <= TIME_WIDTH'(tap_max_ms_ff))
                    && (gap > TIME_WIDTH'(tap_gap_ms_ff));
   assign negative   = (ady >= adx) ? (s1_y_ff < origin_y_ff) : (s1_x_ff < origin_x_ff);
   assign ev_gesture = ev_tap ? GESTURE_TAP : (negative ? GESTURE_NEXT : GESTURE_PREV);

   assign produce    = ev_tap || ev_slide;
   assign advance    = s1_valid_ff && (!produce || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   always_comb begin
      pressed_in    = pressed_ff;
      moved_in      = moved_ff;
      origin_x_in   = origin_x_ff;
      origin_y_in   = origin_y_ff;
      press_time_in = press_time_ff;
      last_event_in = last_event_ff;
      if (press_start) begin
         pressed_in    = 1'b1;
         moved_in      = 1'b0;
         origin_x_in   = s1_x_ff;
         origin_y_in   = s1_y_ff;
         press_time_in = s1_now_ff;
      end else if (holding) begin
         moved_in = moved_now && !ev_slide;
         if (ev_slide) begin
            origin_x_in   = s1_x_ff;
            origin_y_in   = s1_y_ff;
            last_event_in = s1_now_ff;
         end
      end else if (releasing) begin
         pressed_in = 1'b0;
         if (ev_tap) begin
            last_event_in = s1_now_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pressed_ff    <= 1'b0;
         moved_ff      <= 1'b0;
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         press_time_ff <= '0;
         last_event_ff <= '0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (advance) begin
            pressed_ff    <= pressed_in;
            moved_ff      <= moved_in;
            origin_x_ff   <= origin_x_in;
            origin_y_ff   <= origin_y_in;
            press_time_ff <= press_time_in;
            last_event_ff <= last_event_in;
         end
         if (advance && produce) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_touched_ff <= req_tuser[0];
         s1_x_ff       <= req_tdata[CW-1:0];
         s1_y_ff       <= req_tdata[2*CW-1:CW];
         s1_now_ff     <= req_tdata[2*CW+TIME_WIDTH-1:2*CW];
      end
      if (advance && produce) begin
         rsp_gesture_ff <= ev_gesture;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_gesture_ff};

   a_gesture_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_gesture_ff != 2'd3))
      else $error("Result holds an undefined gesture code.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready && s1_valid_ff && produce) |-> !advance)
      else $error("Pending result would be overwritten.");

   a_tap_ends_press: assert property (@(posedge clock) disable iff (reset)
      (advance && ev_tap) |=> !pressed_ff)
      else $error("Press phase still active after a tap.");

   a_slide_rearms: assert property (@(posedge clock) disable iff (reset)
      (advance && ev_slide) |=> (pressed_ff && !moved_ff))
      else $error("Slide did not restart the press.");

   a_event_time: assert property (@(posedge clock) disable iff (reset)
      (advance && produce) |=> (last_event_ff == $past(s1_now_ff)))
      else $error("Last event time not updated on an event.");

endmodule

// File: verif/ttsd_gesture_checker.sv
// Checker that predicts and compares the gestures of the touch tap and swipe detector.
module ttsd_gesture_checker #(
   parameter int REQ_TDATA_WIDTH = ((2*ttsd_pkg::PX_WIDTH + ttsd_pkg::TIME_WIDTH + 7)/8)*8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   input  logic [0:0] req_tuser,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [ttsd_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [ttsd_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   input  logic csr_pready,
   output int fail_count,
   output int pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import ttsd_pkg::*;

   logic [PX_WIDTH-1:0] cfg_tap_max_px;
   logic [MS_WIDTH-1:0] cfg_tap_max_ms;
   logic [PX_WIDTH-1:0] cfg_slide_min_px;
   logic [MS_WIDTH-1:0] cfg_tap_gap_ms;
   logic [MS_WIDTH-1:0] cfg_slide_gap_ms;

   logic down_phase;
   logic [PX_WIDTH-1:0] start_x;
   logic [PX_WIDTH-1:0] start_y;
   logic [TIME_WIDTH-1:0] press_ms;
   logic moved;
   logic [TIME_WIDTH-1:0] last_event_ms;

   gesture_type gesture_q[$];
   int errors = 0;
   int outstanding = 0;

   assign fail_count = errors;
   assign pending_count = outstanding;

   function automatic logic [PX_WIDTH-1:0] coord_dist(input logic [PX_WIDTH-1:0] a,
                                                      input logic [PX_WIDTH-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   task automatic predict_gesture(input logic touched, input logic [PX_WIDTH-1:0] x,
                                  input logic [PX_WIDTH-1:0] y,
                                  input logic [TIME_WIDTH-1:0] stamp);
      logic [TIME_WIDTH-1:0] held_ms;
      logic [TIME_WIDTH-1:0] since_event;
      logic [PX_WIDTH-1:0] adx;
      logic [PX_WIDTH-1:0] ady;
      logic negative;
      if (touched) begin
         if (!down_phase) begin
            down_phase = 1'b1;
            start_x = x;
            start_y = y;
            press_ms = stamp;
            moved = 1'b0;
         end else if (coord_dist(x, start_x) > cfg_tap_max_px ||
                      coord_dist(y, start_y) > cfg_tap_max_px) begin
            moved = 1'b1;
         end
      end else if (down_phase) begin
         held_ms = stamp - press_ms;
         since_event = stamp - last_event_ms;
         if (!moved && held_ms <= cfg_tap_max_ms && since_event > cfg_tap_gap_ms) begin
            gesture_q.push_back(GESTURE_TAP);
            last_event_ms = stamp;
         end
         down_phase = 1'b0;
      end
      if (down_phase && moved) begin
         adx = coord_dist(x, start_x);
         ady = coord_dist(y, start_y);
         since_event = stamp - last_event_ms;
         if ((adx >= cfg_slide_min_px || ady >= cfg_slide_min_px) &&
             since_event > cfg_slide_gap_ms) begin
            if (ady >= adx) begin
               negative = y < start_y;
            end else begin
               negative = x < start_x;
            end
            gesture_q.push_back(negative ? GESTURE_NEXT : GESTURE_PREV);
            last_event_ms = stamp;
            start_x = x;
            start_y = y;
            moved = 1'b0;
         end
      end
   endtask

   always @(posedge clock) begin : monitor
      gesture_type want;
      if (reset) begin
         cfg_tap_max_px = TAP_MAX_PX_RESET;
         cfg_tap_max_ms = TAP_MAX_MS_RESET;
         cfg_slide_min_px = SLIDE_MIN_PX_RESET;
         cfg_tap_gap_ms = TAP_GAP_MS_RESET;
         cfg_slide_gap_ms = SLIDE_GAP_MS_RESET;
         down_phase = 1'b0;
         start_x = '0;
         start_y = '0;
         press_ms = '0;
         moved = 1'b0;
         last_event_ms = '0;
         gesture_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]))
               REG_TAP_MAX_PX: cfg_tap_max_px = csr_pwdata[PX_WIDTH-1:0];
               REG_TAP_MAX_MS: cfg_tap_max_ms = csr_pwdata[MS_WIDTH-1:0];
               REG_SLIDE_MIN_PX: cfg_slide_min_px = csr_pwdata[PX_WIDTH-1:0];
               REG_TAP_GAP_MS: cfg_tap_gap_ms = csr_pwdata[MS_WIDTH-1:0];
               REG_SLIDE_GAP_MS: cfg_slide_gap_ms = csr_pwdata[MS_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_gesture(req_tuser[0], req_tdata[PX_WIDTH-1:0],
                            req_tdata[2*PX_WIDTH-1:PX_WIDTH],
                            req_tdata[2*PX_WIDTH+TIME_WIDTH-1:2*PX_WIDTH]);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (gesture_q.size() == 0) begin
               $error("gesture: no request pending, actual %0d", rsp_tdata[1:0]);
               errors++;
            end else begin
               want = gesture_q.pop_front();
               if (rsp_tdata[1:0] !== want) begin
                  $error("gesture mismatch: expected %0d, actual %0d", want, rsp_tdata[1:0]);
                  errors++;
               end
            end
         end
      end
      outstanding = gesture_q.size();
   end

endmodule

// File: verif/tb_touch_tap_swipe_detector.sv
// Testbench top for the touch tap and swipe detector: stimulus, idling and verdict.
module tb_touch_tap_swipe_detector;
   timeunit 1ns;
   timeprecision 1ps;
   import ttsd_pkg::*;

   localparam int REQ_TDATA_WIDTH = ((2*PX_WIDTH + TIME_WIDTH + 7)/8)*8;
   localparam int COORD_MAX = (1 << PX_WIDTH) - 1;
   localparam int HOLD_CYCLES = 300;
   localparam int RUN_LIMIT_NS = 2_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   int fail_count;
   int pending_count;
   int sent_polls = 0;
   bit quiet = 1'b0;
   bit hold_start = 1'b0;
   bit rsp_hold = 1'b0;
   logic [TIME_WIDTH-1:0] now_ms = '0;
   int set_tap_px = int'(TAP_MAX_PX_RESET);
   int set_tap_ms = int'(TAP_MAX_MS_RESET);
   int set_slide_px = int'(SLIDE_MIN_PX_RESET);
   int set_tap_gap = int'(TAP_GAP_MS_RESET);
   int set_slide_gap = int'(SLIDE_GAP_MS_RESET);

   always #2 clock = ~clock;

   touch_tap_swipe_detector #(.COORD_WIDTH(PX_WIDTH)) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   ttsd_gesture_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_pready(csr_pready),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   function automatic int clamp_coord(input int v);
      return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
   endfunction

   function automatic int offset(input int span);
      return int'($urandom_range(0, 2*span)) - span;
   endfunction

   function automatic int gap_span();
      return ((set_tap_gap > set_slide_gap) ? set_tap_gap : set_slide_gap) + 60;
   endfunction

   task automatic send_poll(input bit touched, input int x, input int y,
                            input logic [TIME_WIDTH-1:0] stamp);
      logic [PX_WIDTH-1:0] px;
      logic [PX_WIDTH-1:0] py;
      px = PX_WIDTH'(x);
      py = PX_WIDTH'(y);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= touched;
      req_tdata <= REQ_TDATA_WIDTH'({stamp, py, px});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_polls++;
      @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input int unsigned value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic apply_settings(input int tap_px, input int tap_ms, input int slide_px,
                                 input int tap_gap, input int slide_gap);
      csr_write(REG_TAP_MAX_PX, tap_px);
      csr_write(REG_TAP_MAX_MS, tap_ms);
      csr_write(REG_SLIDE_MIN_PX, slide_px);
      csr_write(REG_TAP_GAP_MS, tap_gap);
      csr_write(REG_SLIDE_GAP_MS, slide_gap);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      set_tap_px = tap_px;
      set_tap_ms = tap_ms;
      set_slide_px = slide_px;
      set_tap_gap = tap_gap;
      set_slide_gap = slide_gap;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic tap_gesture();
      int x0;
      int y0;
      int holds;
      int dur;
      int span;
      logic [TIME_WIDTH-1:0] pressed_at;
      x0 = $urandom_range(0, COORD_MAX);
      y0 = $urandom_range(0, COORD_MAX);
      now_ms += $urandom_range(0, gap_span());
      pressed_at = now_ms;
      send_poll(1'b1, x0, y0, now_ms);
      holds = $urandom_range(0, 3);
      dur = $urandom_range(0, set_tap_ms + 40);
      span = ($urandom_range(0, 7) == 0) ? set_tap_px + 4 : set_tap_px;
      for (int i = 1; i <= holds; i++) begin
         send_poll(1'b1, clamp_coord(x0 + offset(span)), clamp_coord(y0 + offset(span)),
                   pressed_at + dur * i / (holds + 1));
      end
      now_ms = pressed_at + dur;
      send_poll(1'b0, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), now_ms);
   endtask

   task automatic swipe_gesture();
      int x;
      int y;
      int moves;
      int stride;
      int dir;
      int across;
      bit horizontal;
      x = $urandom_range(0, COORD_MAX);
      y = $urandom_range(0, COORD_MAX);
      now_ms += $urandom_range(0, gap_span());
      send_poll(1'b1, x, y, now_ms);
      horizontal = 1'($urandom_range(0, 1));
      dir = $urandom_range(0, 1) ? 1 : -1;
      stride = $urandom_range(1, set_slide_px / 2 + 8);
      moves = $urandom_range(2, 12);
      repeat (moves) begin
         across = offset(stride / 2);
         if (horizontal) begin
            x = clamp_coord(x + dir * stride);
            y = clamp_coord(y + across);
         end else begin
            y = clamp_coord(y + dir * stride);
            x = clamp_coord(x + across);
         end
         now_ms += $urandom_range(1, 80);
         send_poll(1'b1, x, y, now_ms);
      end
      now_ms += $urandom_range(1, 80);
      send_poll(1'b0, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), now_ms);
   endtask

   task automatic noise_poll();
      if ($urandom_range(0, 7) == 0) begin
         now_ms = $urandom;
      end else begin
         now_ms += $urandom_range(0, 500);
      end
      send_poll(1'($urandom_range(0, 1)), $urandom_range(0, COORD_MAX),
                $urandom_range(0, COORD_MAX), now_ms);
   endtask

   task automatic run_random(input int polls);
      int stop_at;
      stop_at = sent_polls + polls;
      while (sent_polls < stop_at) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: tap_gesture();
            4, 5, 6, 7: swipe_gesture();
            default: noise_poll();
         endcase
      end
   endtask

   initial begin : rsp_sink
      forever begin
         @(negedge clock);
         if (rsp_hold) begin
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : rsp_long_hold
      wait (hold_start);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      send_poll(1'b0, COORD_MAX, COORD_MAX, 32'd1000);
      send_poll(1'b1, 500, 500, 32'd1200);
      send_poll(1'b1, 510, 490, 32'd1250);
      send_poll(1'b0, 0, 0, 32'd1300);
      send_poll(1'b1, COORD_MAX, 0, 32'd2000);
      send_poll(1'b1, 1000, 0, 32'd2010);
      send_poll(1'b1, 980, 0, 32'd2020);
      send_poll(1'b0, 0, 0, 32'd2200);
      send_poll(1'b1, 0, COORD_MAX, 32'd3000);
      send_poll(1'b1, 30, 993, 32'd3010);
      send_poll(1'b1, 50, 973, 32'd3020);
      send_poll(1'b1, 50, COORD_MAX, 32'd3300);
      send_poll(1'b0, 0, 0, 32'd3400);
      send_poll(1'b1, 0, 0, 32'hFFFF_FFF0);
      send_poll(1'b0, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF);
      send_poll(1'b1, 0, 0, 32'h0000_0040);
      send_poll(1'b1, COORD_MAX, 0, 32'h0000_0041);
      send_poll(1'b1, COORD_MAX, 0, 32'h0000_0200);
      send_poll(1'b0, 0, 0, 32'h0000_0240);
      send_poll(1'b1, 300, 300, 32'h0000_0250);
      send_poll(1'b0, 300, 300, 32'h0000_0260);
      send_poll(1'b1, 700, 100, 32'h0000_1000);
      send_poll(1'b0, 700, 100, 32'h0000_1000 + 300);
      now_ms = 32'h0000_2000;
      settle();

      apply_settings(0, 0, 0, 0, 0);
      run_random(120);
      settle();

      apply_settings(COORD_MAX, 65535, COORD_MAX, 65535, 65535);
      run_random(120);
      settle();

      apply_settings(TAP_MAX_PX_RESET, TAP_MAX_MS_RESET, SLIDE_MIN_PX_RESET,
                     TAP_GAP_MS_RESET, SLIDE_GAP_MS_RESET);
      run_random(200);
      settle();

      apply_settings($urandom_range(0, 60), $urandom_range(50, 1000), $urandom_range(5, 120),
                     $urandom_range(0, 400), $urandom_range(0, 400));
      run_random(150);
      settle();

      // Every move that changes the position now raises a slide, so a held result channel backs up into the requests.
      apply_settings(0, 300, 1, 0, 0);
      hold_start = 1'b1;
      repeat (10) swipe_gesture();
      settle();

      quiet = 1'b1;
      apply_settings($urandom_range(0, 60), $urandom_range(50, 1000), $urandom_range(5, 120),
                     $urandom_range(0, 400), $urandom_range(0, 400));
      run_random(120);
      settle();

      if (fail_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
